### rtl/core/ethf_pkg.sv
// ----------------------------------------------------------------------------
// ethf_pkg: event time histogram finder shared definitions
// Field widths, fixed constants, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package ethf_pkg;

	// Default sizes of the stores
	localparam int NUM_LAYERS_DEF = 9;
	localparam int NUM_CLOCKS_DEF = 64;
	localparam int SCAN_BINS_DEF  = 150;

	// Field widths
	localparam int TIME_W  = 13;
	localparam int LAYER_W = 4;
	localparam int PAIR_W  = 4;
	localparam int BIN_W   = 13;
	localparam int ET_W    = 8;

	// Hit selection and histogram constants
	localparam int CLK_DIV_SHIFT   = 4;
	localparam int CLK_OFFSET      = 31;
	localparam int MAX_TIME_DIFF   = 256;
	localparam int PAIR_LIMIT      = 10;
	localparam int BIN_TIME_OFFSET = 51;
	localparam int REPORT_OFFSET   = 50;
	localparam int BIN_MAX         = 8191;

	// Configuration register indexes
	localparam logic [0:0] CFG_THRESHOLD = 1'b0;
	localparam logic [0:0] CFG_TRUE_TIME = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HIT_ADDR,
		ST_HIT_RD,
		ST_HIT_PAIR,
		ST_HIT_BIN,
		ST_SCAN,
		ST_CLEAR,
		ST_DONE
	} ethf_state_t;

	// Memory strobes from the sequencer to the stores
	typedef struct packed {
		logic pair_rd;
		logic pair_we;
		logic bin_rd;
		logic bin_we;
	} ethf_mem_ctl_t;

endpackage

### rtl/core/ethf_if.sv
// ----------------------------------------------------------------------------
// ethf_if: item and result channels
// Valid/ready channels carrying one segment hit or end of event, and one result.
// ----------------------------------------------------------------------------
interface ethf_item_if;
	logic                                valid;
	logic                                ready;
	logic                                func;
	logic signed [ethf_pkg::TIME_W-1:0]  found_time;
	logic signed [ethf_pkg::TIME_W-1:0]  fastest_time;
	logic        [ethf_pkg::LAYER_W-1:0] super_layer;

	modport source (output valid, func, found_time, fastest_time, super_layer, input ready);
	modport sink (input valid, func, found_time, fastest_time, super_layer, output ready);
endinterface

interface ethf_result_if;
	logic                              valid;
	logic                              ready;
	logic                              time_found;
	logic signed [ethf_pkg::ET_W-1:0]  event_time;

	modport source (output valid, time_found, event_time, input ready);
	modport sink (input valid, time_found, event_time, output ready);
endinterface

### rtl/core/event_time_histogram_finder_top.sv
// ----------------------------------------------------------------------------
// event_time_histogram_finder_top: event time finder
// Histograms the fastest times of selected segment hits and reports the
// first time bin above threshold at each end of event.
// ----------------------------------------------------------------------------
// Usage:
//   item carries one transaction per segment hit (func 0) or end of event
//   (func 1). result carries one transaction per end of event: time_found
//   and event_time. cfg_we/cfg_index/cfg_data write threshold (index 0) and
//   true_time_mode (index 1); write only while the block is idle.
// Steps:
//   A hit runs accept, decode, memory read, counter update and bin update
//   (read-modify-write through the single-port stores and the shared
//   compare/increment unit); the bin update is skipped when its pair is
//   full or its fastest time lies outside the histogram, a hit dropped by
//   the window checks ends after decode and one taken in true_time_mode
//   ends at accept. An end of event runs the threshold scan (skipped in
//   true_time_mode), clears max(NUM_LAYERS*NUM_CLOCKS, SCAN_BINS) store
//   addresses (576 by default) and then loads the result register.
// Reset and stalls:
//   After reset the same clearing sweep runs before item.ready rises.
//   The result register holds while result.ready is low; the block keeps
//   taking hits meanwhile and waits only when a second result is ready.
// ----------------------------------------------------------------------------
module event_time_histogram_finder_top #(
	parameter int NUM_LAYERS = ethf_pkg::NUM_LAYERS_DEF,
	parameter int NUM_CLOCKS = ethf_pkg::NUM_CLOCKS_DEF,
	parameter int SCAN_BINS  = ethf_pkg::SCAN_BINS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [ethf_pkg::BIN_W-1:0] cfg_data,
	ethf_item_if.sink                  item,
	ethf_result_if.source              result
);

	localparam int NUM_PAIRS = NUM_LAYERS * NUM_CLOCKS;
	localparam int PAIR_AW   = $clog2(NUM_PAIRS);
	localparam int BIN_AW    = $clog2(SCAN_BINS);

	logic [ethf_pkg::BIN_W-1:0]  threshold_q;
	logic                        true_time_q;
	logic [ethf_pkg::BIN_W-1:0]  alu_a;
	logic [ethf_pkg::BIN_W-1:0]  alu_b;
	logic                        alu_gt;
	logic [ethf_pkg::BIN_W-1:0]  alu_inc;
	ethf_pkg::ethf_mem_ctl_t     mem_ctl;
	logic [PAIR_AW-1:0]          pair_addr;
	logic [ethf_pkg::PAIR_W-1:0] pair_wdata;
	logic [ethf_pkg::PAIR_W-1:0] pair_rdata;
	logic [BIN_AW-1:0]           bin_addr;
	logic [ethf_pkg::BIN_W-1:0]  bin_wdata;
	logic [ethf_pkg::BIN_W-1:0]  bin_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= ethf_pkg::BIN_W'(3);
			true_time_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ethf_pkg::CFG_THRESHOLD: begin
					threshold_q <= cfg_data;
				end
				ethf_pkg::CFG_TRUE_TIME: begin
					true_time_q <= cfg_data[0];
				end
				default: begin
					threshold_q <= threshold_q;
				end
			endcase
		end
	end

	ethf_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.gt  (alu_gt),
		.inc (alu_inc)
	);

	ethf_stores #(
		.NUM_LAYERS (NUM_LAYERS),
		.NUM_CLOCKS (NUM_CLOCKS),
		.SCAN_BINS  (SCAN_BINS)
	) u_stores (
		.clk        (clk),
		.ctl        (mem_ctl),
		.pair_addr  (pair_addr),
		.pair_wdata (pair_wdata),
		.pair_rdata (pair_rdata),
		.bin_addr   (bin_addr),
		.bin_wdata  (bin_wdata),
		.bin_rdata  (bin_rdata)
	);

	ethf_seq #(
		.NUM_LAYERS (NUM_LAYERS),
		.NUM_CLOCKS (NUM_CLOCKS),
		.SCAN_BINS  (SCAN_BINS)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.result         (result),
		.threshold      (threshold_q),
		.true_time_mode (true_time_q),
		.alu_a          (alu_a),
		.alu_b          (alu_b),
		.alu_gt         (alu_gt),
		.alu_inc        (alu_inc),
		.mem_ctl        (mem_ctl),
		.pair_addr      (pair_addr),
		.pair_wdata     (pair_wdata),
		.pair_rdata     (pair_rdata),
		.bin_addr       (bin_addr),
		.bin_wdata      (bin_wdata),
		.bin_rdata      (bin_rdata)
	);

endmodule

### rtl/core/ethf_alu.sv
// ----------------------------------------------------------------------------
// ethf_alu: shared compare and increment unit
// One magnitude compare and one incrementer, time-shared by the sequencer.
// ----------------------------------------------------------------------------
module ethf_alu (
	input  logic [ethf_pkg::BIN_W-1:0] a,
	input  logic [ethf_pkg::BIN_W-1:0] b,
	output logic                       gt,
	output logic [ethf_pkg::BIN_W-1:0] inc
);

	assign gt  = a > b;
	assign inc = a + ethf_pkg::BIN_W'(1);

endmodule

### rtl/core/ethf_stores.sv
// ----------------------------------------------------------------------------
// ethf_stores: pair counter and histogram memories
// Single-port memories with registered read data.
// ----------------------------------------------------------------------------
module ethf_stores #(
	parameter int NUM_LAYERS = ethf_pkg::NUM_LAYERS_DEF,
	parameter int NUM_CLOCKS = ethf_pkg::NUM_CLOCKS_DEF,
	parameter int SCAN_BINS  = ethf_pkg::SCAN_BINS_DEF,
	localparam int NUM_PAIRS = NUM_LAYERS * NUM_CLOCKS,
	localparam int PAIR_AW   = $clog2(NUM_PAIRS),
	localparam int BIN_AW    = $clog2(SCAN_BINS)
) (
	input  logic                          clk,
	input  ethf_pkg::ethf_mem_ctl_t       ctl,
	input  logic [PAIR_AW-1:0]            pair_addr,
	input  logic [ethf_pkg::PAIR_W-1:0]   pair_wdata,
	output logic [ethf_pkg::PAIR_W-1:0]   pair_rdata,
	input  logic [BIN_AW-1:0]             bin_addr,
	input  logic [ethf_pkg::BIN_W-1:0]    bin_wdata,
	output logic [ethf_pkg::BIN_W-1:0]    bin_rdata
);

	logic [ethf_pkg::PAIR_W-1:0] pair_mem [NUM_PAIRS];
	logic [ethf_pkg::BIN_W-1:0]  bin_mem [SCAN_BINS];

	always_ff @(posedge clk) begin
		if (ctl.pair_we) begin
			pair_mem[pair_addr] <= pair_wdata;
		end
		if (ctl.pair_rd) begin
			pair_rdata <= pair_mem[pair_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.bin_we) begin
			bin_mem[bin_addr] <= bin_wdata;
		end
		if (ctl.bin_rd) begin
			bin_rdata <= bin_mem[bin_addr];
		end
	end

endmodule

### rtl/core/ethf_seq.sv
// ----------------------------------------------------------------------------
// ethf_seq: event time finder sequencer
// Decodes hits, runs the counter/histogram updates, the threshold scan,
// the store clearing sweep and holds the result register.
// ----------------------------------------------------------------------------
module ethf_seq #(
	parameter int NUM_LAYERS = ethf_pkg::NUM_LAYERS_DEF,
	parameter int NUM_CLOCKS = ethf_pkg::NUM_CLOCKS_DEF,
	parameter int SCAN_BINS  = ethf_pkg::SCAN_BINS_DEF,
	localparam int NUM_PAIRS = NUM_LAYERS * NUM_CLOCKS,
	localparam int CLEAR_LEN = (NUM_PAIRS > SCAN_BINS) ? NUM_PAIRS : SCAN_BINS,
	localparam int PAIR_AW   = $clog2(NUM_PAIRS),
	localparam int BIN_AW    = $clog2(SCAN_BINS),
	localparam int CNT_W     = $clog2(CLEAR_LEN + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ethf_item_if.sink                     item,
	ethf_result_if.source                 result,
	input  logic [ethf_pkg::BIN_W-1:0]    threshold,
	input  logic                          true_time_mode,
	output logic [ethf_pkg::BIN_W-1:0]    alu_a,
	output logic [ethf_pkg::BIN_W-1:0]    alu_b,
	input  logic                          alu_gt,
	input  logic [ethf_pkg::BIN_W-1:0]    alu_inc,
	output ethf_pkg::ethf_mem_ctl_t       mem_ctl,
	output logic [PAIR_AW-1:0]            pair_addr,
	output logic [ethf_pkg::PAIR_W-1:0]   pair_wdata,
	input  logic [ethf_pkg::PAIR_W-1:0]   pair_rdata,
	output logic [BIN_AW-1:0]             bin_addr,
	output logic [ethf_pkg::BIN_W-1:0]    bin_wdata,
	input  logic [ethf_pkg::BIN_W-1:0]    bin_rdata
);

	ethf_pkg::ethf_state_t state_q, state_d;

	logic signed [ethf_pkg::TIME_W-1:0]  found_q;
	logic signed [ethf_pkg::TIME_W-1:0]  fastest_q;
	logic        [ethf_pkg::LAYER_W-1:0] layer_q;
	logic        [PAIR_AW-1:0]           pair_addr_q;
	logic        [BIN_AW-1:0]            bin_addr_q;
	logic                                bin_ok_q;
	logic                                kept;
	logic                                bin_ok;
	logic        [PAIR_AW-1:0]           pair_idx;
	logic        [BIN_AW-1:0]            bin_idx;
	logic        [CNT_W-1:0]             cnt_q;
	logic                                cnt_step;
	logic                                rd_vld_s1;
	logic        [BIN_AW-1:0]            rd_idx_s1;
	logic                                hit_now;
	logic                                res_found_q;
	logic        [ethf_pkg::ET_W-1:0]    res_time_q;
	logic                                evt_q;
	logic                                out_valid_q;
	logic                                out_found_q;
	logic        [ethf_pkg::ET_W-1:0]    out_time_q;
	logic                                slot_free;
	logic                                accept;

	// Hit decode: clock index, time window, layer and histogram bin
	logic signed [ethf_pkg::TIME_W-1:0] quo;
	logic                               rnd_up;
	logic signed [9:0]                  clk_s;
	logic signed [13:0]                 diff_s;
	logic signed [13:0]                 bin_s;
	logic        [15:0]                 pair_full;

	always_comb begin
		quo    = found_q >>> ethf_pkg::CLK_DIV_SHIFT;
		// round toward zero for negative times with a remainder
		rnd_up = found_q[ethf_pkg::TIME_W-1] && (found_q[ethf_pkg::CLK_DIV_SHIFT-1:0] != '0);
		clk_s  = quo[9:0] + {9'd0, rnd_up} + 10'(ethf_pkg::CLK_OFFSET);
		diff_s = {found_q[ethf_pkg::TIME_W-1], found_q}
			- {fastest_q[ethf_pkg::TIME_W-1], fastest_q};
		bin_s  = {fastest_q[ethf_pkg::TIME_W-1], fastest_q} + 14'(ethf_pkg::BIN_TIME_OFFSET);
		kept   = !clk_s[9] && ({1'b0, clk_s[8:0]} < 10'(NUM_CLOCKS))
			&& (diff_s <= $signed(14'(ethf_pkg::MAX_TIME_DIFF)))
			&& (5'(layer_q) < 5'(NUM_LAYERS));
		bin_ok = !bin_s[13] && ($unsigned(bin_s) < 14'(SCAN_BINS));
		pair_full = 16'(layer_q) * 16'(NUM_CLOCKS) + 16'(clk_s[8:0]);
		pair_idx  = pair_full[PAIR_AW-1:0];
		bin_idx   = bin_s[BIN_AW-1:0];
	end

	assign slot_free  = !out_valid_q || result.ready;
	assign item.ready = (state_q == ethf_pkg::ST_IDLE);
	assign accept     = item.valid && item.ready;

	assign result.valid      = out_valid_q;
	assign result.time_found = out_found_q;
	assign result.event_time = out_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ethf_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mem_ctl    = '0;
		alu_a      = bin_rdata;
		alu_b      = threshold;
		pair_addr  = pair_addr_q;
		bin_addr   = bin_addr_q;
		pair_wdata = alu_inc[ethf_pkg::PAIR_W-1:0];
		bin_wdata  = alu_inc;
		cnt_step   = 1'b0;
		hit_now    = 1'b0;
		case (state_q)
			ethf_pkg::ST_IDLE: begin
				if (accept) begin
					if (item.func) begin
						state_d = true_time_mode ? ethf_pkg::ST_CLEAR : ethf_pkg::ST_SCAN;
					end else if (!true_time_mode) begin
						state_d = ethf_pkg::ST_HIT_ADDR;
					end
				end
			end
			ethf_pkg::ST_HIT_ADDR: begin
				state_d = kept ? ethf_pkg::ST_HIT_RD : ethf_pkg::ST_IDLE;
			end
			ethf_pkg::ST_HIT_RD: begin
				mem_ctl.pair_rd = 1'b1;
				mem_ctl.bin_rd  = bin_ok_q;
				state_d         = ethf_pkg::ST_HIT_PAIR;
			end
			ethf_pkg::ST_HIT_PAIR: begin
				alu_a = ethf_pkg::BIN_W'(pair_rdata);
				alu_b = ethf_pkg::BIN_W'(ethf_pkg::PAIR_LIMIT - 1);
				if (!alu_gt) begin
					mem_ctl.pair_we = 1'b1;
					state_d = bin_ok_q ? ethf_pkg::ST_HIT_BIN : ethf_pkg::ST_IDLE;
				end else begin
					state_d = ethf_pkg::ST_IDLE;
				end
			end
			ethf_pkg::ST_HIT_BIN: begin
				alu_b = ethf_pkg::BIN_W'(ethf_pkg::BIN_MAX - 1);
				// saturate the bin
				mem_ctl.bin_we = !alu_gt;
				state_d        = ethf_pkg::ST_IDLE;
			end
			ethf_pkg::ST_SCAN: begin
				hit_now        = rd_vld_s1 && alu_gt;
				bin_addr       = cnt_q[BIN_AW-1:0];
				mem_ctl.bin_rd = (cnt_q < CNT_W'(SCAN_BINS)) && !hit_now;
				cnt_step       = mem_ctl.bin_rd;
				if (hit_now || (!rd_vld_s1 && (cnt_q == CNT_W'(SCAN_BINS)))) begin
					state_d = ethf_pkg::ST_CLEAR;
				end
			end
			ethf_pkg::ST_CLEAR: begin
				pair_addr       = cnt_q[PAIR_AW-1:0];
				bin_addr        = cnt_q[BIN_AW-1:0];
				pair_wdata      = '0;
				bin_wdata       = '0;
				mem_ctl.pair_we = (cnt_q < CNT_W'(NUM_PAIRS));
				mem_ctl.bin_we  = (cnt_q < CNT_W'(SCAN_BINS));
				cnt_step        = 1'b1;
				if (cnt_q == CNT_W'(CLEAR_LEN - 1)) begin
					state_d = evt_q ? ethf_pkg::ST_DONE : ethf_pkg::ST_IDLE;
				end
			end
			ethf_pkg::ST_DONE: begin
				if (slot_free) begin
					state_d = ethf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ethf_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			evt_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// restart the sweep counter on every state change
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (cnt_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			rd_vld_s1 <= (state_q == ethf_pkg::ST_SCAN) && mem_ctl.bin_rd;
			if (accept && item.func) begin
				evt_q <= 1'b1;
			end else if (state_q == ethf_pkg::ST_DONE && slot_free) begin
				evt_q <= 1'b0;
			end
			if (state_q == ethf_pkg::ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			found_q     <= item.found_time;
			fastest_q   <= item.fastest_time;
			layer_q     <= item.super_layer;
			res_found_q <= true_time_mode;
			res_time_q  <= '0;
		end
		if (state_q == ethf_pkg::ST_HIT_ADDR) begin
			pair_addr_q <= pair_idx;
			bin_addr_q  <= bin_idx;
			bin_ok_q    <= bin_ok;
		end
		rd_idx_s1 <= cnt_q[BIN_AW-1:0];
		if (hit_now) begin
			res_found_q <= 1'b1;
			res_time_q  <= ethf_pkg::ET_W'(16'(rd_idx_s1) - 16'(ethf_pkg::REPORT_OFFSET));
		end
		if (state_q == ethf_pkg::ST_DONE && slot_free) begin
			out_found_q <= res_found_q;
			out_time_q  <= res_time_q;
		end
	end

endmodule
